>>> hdl/buf_uart_pkg.sv
package buf_uart_pkg;

  localparam int unsigned NumStats = 9;

  localparam logic [2:0] KIND_SEND  = 3'd0;
  localparam logic [2:0] KIND_RECV  = 3'd1;
  localparam logic [2:0] KIND_EVENT = 3'd2;
  localparam logic [2:0] KIND_STAT  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam int unsigned STAT_OVERRUN  = 0;
  localparam int unsigned STAT_FRAMING  = 1;
  localparam int unsigned STAT_NOISE    = 2;
  localparam int unsigned STAT_PARITY   = 3;
  localparam int unsigned STAT_TX_OVF   = 4;
  localparam int unsigned STAT_RX_OVF   = 5;
  localparam int unsigned STAT_EVENTS   = 6;
  localparam int unsigned STAT_RX_BYTES = 7;
  localparam int unsigned STAT_TX_BYTES = 8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEND,
    OP_RECV,
    OP_EVENT,
    OP_STAT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] stat_index;
    logic       flag_overrun;
    logic       flag_framing;
    logic       flag_noise;
    logic       flag_parity;
    logic       flag_rx_ready;
    logic       flag_tx_ready;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  read_byte;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_irq_enabled;
    logic        service_request;
    logic [31:0] stat_value;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [3:0] stat_index;
    logic       any_error;
    logic [3:0] errors;
    logic       rx_ready;
    logic       tx_ready;
  } cmd_t;

endpackage

>>> hdl/buf_uart_ram.sv
module buf_uart_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/buf_uart_front.sv
module buf_uart_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  buf_uart_pkg::in_item_t in_data_i,
  output logic                  cmd_valid_o,
  output buf_uart_pkg::cmd_t    cmd_o,
  input  logic                  cmd_pop_i
);

  buf_uart_pkg::cmd_t ent_q [2];
  buf_uart_pkg::cmd_t cmd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       hd_q, hd_d;
  logic       push;

  // classify the incoming word
  always_comb begin
    cmd_d            = '0;
    cmd_d.data       = in_data_i.data;
    cmd_d.stat_index = in_data_i.stat_index;
    cmd_d.errors     = {in_data_i.flag_overrun, in_data_i.flag_framing,
                        in_data_i.flag_noise, in_data_i.flag_parity};
    cmd_d.any_error  = in_data_i.flag_overrun | in_data_i.flag_framing |
                       in_data_i.flag_noise | in_data_i.flag_parity;
    cmd_d.rx_ready   = in_data_i.flag_rx_ready;
    cmd_d.tx_ready   = in_data_i.flag_tx_ready;
    case (in_data_i.kind)
      buf_uart_pkg::KIND_SEND:  cmd_d.op = buf_uart_pkg::OP_SEND;
      buf_uart_pkg::KIND_RECV:  cmd_d.op = buf_uart_pkg::OP_RECV;
      buf_uart_pkg::KIND_EVENT: cmd_d.op = buf_uart_pkg::OP_EVENT;
      buf_uart_pkg::KIND_STAT:  cmd_d.op = buf_uart_pkg::OP_STAT;
      buf_uart_pkg::KIND_CLEAR: cmd_d.op = buf_uart_pkg::OP_CLEAR;
      default:                  cmd_d.op = buf_uart_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[hd_q];

  always_comb begin
    cnt_d = cnt_q;
    hd_d  = hd_q;
    if (cmd_pop_i) begin
      hd_d = ~hd_q;
    end
    case ({push, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      hd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      hd_q  <= hd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[hd_q ^ cnt_q[0]] <= cmd_d;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !cmd_pop_i) |=> in_stall_o) else $error("full queue lost a word");

endmodule

>>> hdl/buf_uart_back.sv
module buf_uart_back #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   stats_enable_i,
  input  logic                   cmd_valid_i,
  input  buf_uart_pkg::cmd_t     cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output buf_uart_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned NS = buf_uart_pkg::NumStats;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  logic state_q, state_d;

  logic [AW-1:0] tx_rd_q, tx_rd_d, rx_rd_q, rx_rd_d;
  logic [FW-1:0] tx_fill_q, tx_fill_d, rx_fill_q, rx_fill_d;
  logic          irq_q, irq_d, pend_q, pend_d;
  logic [31:0]   stat_q [NS];
  logic [NS-1:0] bump;

  buf_uart_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic use_rx_q, use_rx_d, use_tx_q, use_tx_d;
  logic out_valid_q;
  logic load_out;

  logic          tx_we, rx_we, tx_re, rx_re;
  logic [AW-1:0] tx_wa, rx_wa;
  logic [7:0]    tx_rdata, rx_rdata;
  logic [SW-1:0] tx_sum, rx_sum;
  logic          tx_full, rx_full, tx_empty, rx_empty;

  assign tx_full  = (tx_fill_q == FW'(FIFO_DEPTH));
  assign rx_full  = (rx_fill_q == FW'(FIFO_DEPTH));
  assign tx_empty = (tx_fill_q == '0);
  assign rx_empty = (rx_fill_q == '0);
  assign tx_sum   = SW'(tx_rd_q) + SW'(tx_fill_q);
  assign rx_sum   = SW'(rx_rd_q) + SW'(rx_fill_q);
  assign tx_wa    = (tx_sum >= SW'(FIFO_DEPTH)) ? AW'(tx_sum - SW'(FIFO_DEPTH)) : AW'(tx_sum);
  assign rx_wa    = (rx_sum >= SW'(FIFO_DEPTH)) ? AW'(rx_sum - SW'(FIFO_DEPTH)) : AW'(rx_sum);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign load_out  = (state_q == ST_DONE) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d   = state_q;
    tx_rd_d   = tx_rd_q;
    rx_rd_d   = rx_rd_q;
    tx_fill_d = tx_fill_q;
    rx_fill_d = rx_fill_q;
    irq_d     = irq_q;
    pend_d    = pend_q;
    bump      = '0;
    res_d     = res_q;
    use_rx_d  = use_rx_q;
    use_tx_d  = use_tx_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    tx_re     = 1'b0;
    rx_re     = 1'b0;
    if (cmd_pop_o) begin
      state_d  = ST_DONE;
      res_d    = '0;
      use_rx_d = 1'b0;
      use_tx_d = 1'b0;
      case (cmd_i.op)
        buf_uart_pkg::OP_SEND: begin
          if (!tx_full) begin
            tx_we     = 1'b1;
            tx_fill_d = tx_fill_q + FW'(1);
            irq_d     = 1'b1;
            res_d.ok  = 1'b1;
          end else begin
            bump[buf_uart_pkg::STAT_TX_OVF] = 1'b1;
          end
        end
        buf_uart_pkg::OP_RECV: begin
          if (!rx_empty) begin
            rx_re     = 1'b1;
            rx_rd_d   = (rx_rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rx_rd_q + AW'(1);
            rx_fill_d = rx_fill_q - FW'(1);
            res_d.ok  = 1'b1;
            use_rx_d  = 1'b1;
          end
        end
        buf_uart_pkg::OP_EVENT: begin
          bump[buf_uart_pkg::STAT_EVENTS] = 1'b1;
          if (cmd_i.any_error) begin
            bump[buf_uart_pkg::STAT_OVERRUN] = cmd_i.errors[3];
            bump[buf_uart_pkg::STAT_FRAMING] = cmd_i.errors[2];
            bump[buf_uart_pkg::STAT_NOISE]   = cmd_i.errors[1];
            bump[buf_uart_pkg::STAT_PARITY]  = cmd_i.errors[0];
          end else begin
            if (cmd_i.rx_ready) begin
              if (!rx_full) begin
                rx_we     = 1'b1;
                rx_fill_d = rx_fill_q + FW'(1);
                bump[buf_uart_pkg::STAT_RX_BYTES] = 1'b1;
                if (!pend_q) begin
                  pend_d                = 1'b1;
                  res_d.service_request = 1'b1;
                end
              end else begin
                bump[buf_uart_pkg::STAT_RX_OVF] = 1'b1;
              end
            end
            if (cmd_i.tx_ready) begin
              if (!tx_empty) begin
                tx_re          = 1'b1;
                tx_rd_d        = (tx_rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : tx_rd_q + AW'(1);
                tx_fill_d      = tx_fill_q - FW'(1);
                res_d.tx_valid = 1'b1;
                use_tx_d       = 1'b1;
                bump[buf_uart_pkg::STAT_TX_BYTES] = 1'b1;
              end else begin
                irq_d = 1'b0;
              end
            end
          end
        end
        buf_uart_pkg::OP_STAT: begin
          if (32'(cmd_i.stat_index) < NS) begin
            res_d.stat_value = stat_q[cmd_i.stat_index];
          end
        end
        buf_uart_pkg::OP_CLEAR: begin
          pend_d = 1'b0;
        end
        default: begin
          res_d = '0;
        end
      endcase
      res_d.tx_irq_enabled = irq_d;
    end else if (load_out) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    out_d           = res_q;
    out_d.read_byte = use_rx_q ? rx_rdata : 8'd0;
    out_d.tx_byte   = use_tx_q ? tx_rdata : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tx_rd_q     <= '0;
      rx_rd_q     <= '0;
      tx_fill_q   <= '0;
      rx_fill_q   <= '0;
      irq_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        stat_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      tx_rd_q   <= tx_rd_d;
      rx_rd_q   <= rx_rd_d;
      tx_fill_q <= tx_fill_d;
      rx_fill_q <= rx_fill_d;
      irq_q     <= irq_d;
      pend_q    <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      for (int i = 0; i < NS; i++) begin
        if (stats_enable_i && bump[i]) begin
          stat_q[i] <= stat_q[i] + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    use_rx_q <= use_rx_d;
    use_tx_q <= use_tx_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  buf_uart_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_wa),
    .wdata_i(cmd_i.data),
    .re_i   (tx_re),
    .raddr_i(tx_rd_q),
    .rdata_o(tx_rdata)
  );

  buf_uart_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_wa),
    .wdata_i(cmd_i.data),
    .re_i   (rx_re),
    .raddr_i(rx_rd_q),
    .rdata_o(rx_rdata)
  );

  a_tx_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_fill_q <= FW'(FIFO_DEPTH)) else $error("tx fill beyond depth");

  a_rx_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fill_q <= FW'(FIFO_DEPTH)) else $error("rx fill beyond depth");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == ST_IDLE) else $error("result not loaded");

  a_srq_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_q.service_request) |-> pend_q)
    else $error("service request without pending");

endmodule

>>> hdl/buffered_uart_fifo_engine.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
// out       output     out_valid_o / out_stall_i  out_data_o (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (stats_enable)
//
// in the execute stage a word first does the fifo and counter update and the ram
// read of a popped byte, then loads the output register
// a two-word queue in front accepts while execute or output stalls until full
// reset clears fifo pointers, fill counts, interrupt and pending flags and stats
// the output register holds its word while out_stall_i is high
module buffered_uart_fifo_engine #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  buf_uart_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output buf_uart_pkg::out_item_t out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_data_i
);

  logic               stats_en_q;
  logic               cmd_valid;
  logic               cmd_pop;
  buf_uart_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stats_en_q <= cfg_data_i;
    end
  end

  buf_uart_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  buf_uart_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stats_enable_i(stats_en_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
